// ----- src/rdcs_pkg.sv -----
// Package for the robot drive command sequencer: item, result and
// configuration types, command codes and the wheel drive helpers.
// No dependencies.
`default_nettype none

package rdcs_pkg;

   // item kinds
   localparam logic [1:0] KIND_TICK = 2'd0;
   localparam logic [1:0] KIND_BYTE = 2'd1;
   localparam logic [1:0] KIND_IR   = 2'd2;

   // command characters
   localparam logic [7:0] BYTE_FWD     = 8'h31;
   localparam logic [7:0] BYTE_REV     = 8'h32;
   localparam logic [7:0] BYTE_RSPIN   = 8'h33;
   localparam logic [7:0] BYTE_LSPIN   = 8'h34;
   localparam logic [7:0] BYTE_NOP     = 8'h35;
   localparam logic [7:0] BYTE_MAN_SIX = 8'h36;
   localparam logic [7:0] BYTE_MAN_SEV = 8'h37;

   localparam logic MANOEUVRE_SIX   = 1'b0;
   localparam logic MANOEUVRE_SEVEN = 1'b1;

   localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEAR_THR   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FWD_PHASE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TURN_END   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FINAL_END  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_REVERSE    = 3'd5;

   // floor(9*s/10) = (s * 9 * 52429) >> 19, exact for 9*s below 43699
   localparam logic [26:0] SPIN_MUL   = 27'd471861;
   localparam int          SPIN_SHIFT = 19;

   typedef struct packed {
      logic [7:0]  speed;
      logic [9:0]  near_threshold;
      logic [15:0] fwd_phase_ms;
      logic [15:0] turn_end_ms;
      logic [15:0] final_end_ms;
      logic [15:0] reverse_ms;
   } cfg_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] rx_byte;
      logic [9:0] ir_sample;
   } item_type;

   typedef struct packed {
      logic       left_forward;
      logic [7:0] left_duty;
      logic       right_forward;
      logic [7:0] right_duty;
      logic       manoeuvre_busy;
   } result_type;

   typedef struct packed {
      logic       forward;
      logic [7:0] duty;
   } wheel_type;

   localparam wheel_type WHEEL_STOP = '{forward: 1'b1, duty: 8'd0};

   // zero drive always reads forward; magnitude never exceeds 255
   function automatic wheel_type drive_wheel(logic reverse, logic [7:0] mag);
      wheel_type w;
      w.forward = !reverse || (mag == 8'd0);
      w.duty    = mag;
      return w;
   endfunction

   function automatic logic [7:0] spin_speed(logic [7:0] speed);
      logic [26:0] prod;
      prod = {19'd0, speed} * SPIN_MUL;
      return prod[SPIN_SHIFT+7:SPIN_SHIFT];
   endfunction

endpackage

`default_nettype wire

// ----- src/rdcs_if.sv -----
// Handshake channels of the sequencer: request items and drive results.
// Plain valid/ready transfer; no dependencies.
`default_nettype none

interface rdcs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] rx_byte;
   logic [9:0] ir_sample;

   modport source (output valid, command, rx_byte, ir_sample, input ready);
   modport sink   (input valid, command, rx_byte, ir_sample, output ready);
endinterface

interface rdcs_rsp_if;
   logic       valid;
   logic       ready;
   logic       left_forward;
   logic [7:0] left_duty;
   logic       right_forward;
   logic [7:0] right_duty;
   logic       manoeuvre_busy;

   modport source (output valid, left_forward, left_duty, right_forward, right_duty,
                   manoeuvre_busy, input ready);
   modport sink   (input valid, left_forward, left_duty, right_forward, right_duty,
                   manoeuvre_busy, output ready);
endinterface

`default_nettype wire

// ----- src/rdcs_cfg_regs.sv -----
// Configuration register file of the sequencer, written through a plain
// write port. Depends on rdcs_pkg.
`default_nettype none

module rdcs_cfg_regs import rdcs_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SPEED:     cfg_in.speed          = csr_wdata[7:0];
            CSR_NEAR_THR:  cfg_in.near_threshold = csr_wdata[9:0];
            CSR_FWD_PHASE: cfg_in.fwd_phase_ms   = csr_wdata;
            CSR_TURN_END:  cfg_in.turn_end_ms    = csr_wdata;
            CSR_FINAL_END: cfg_in.final_end_ms   = csr_wdata;
            CSR_REVERSE:   cfg_in.reverse_ms     = csr_wdata;
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed          <= 8'd255;
         cfg_ff.near_threshold <= 10'd166;
         cfg_ff.fwd_phase_ms   <= 16'd1000;
         cfg_ff.turn_end_ms    <= 16'd3500;
         cfg_ff.final_end_ms   <= 16'd4500;
         cfg_ff.reverse_ms     <= 16'd1000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- src/rdcs_drive_core.sv -----
// Drive state of the sequencer and its single-pass update for one item.
// Depends on rdcs_pkg.
`default_nettype none

module rdcs_drive_core import rdcs_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     update,
   input  wire item_type item,
   input  wire cfg_type  cfg,
   output result_type    result_next
);

   wheel_type   left_ff, left_in;
   wheel_type   right_ff, right_in;
   logic        busy_ff, busy_in;
   logic        kind_ff, kind_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [7:0]  spin;

   assign spin = spin_speed(cfg.speed);

   always_comb begin
      left_in    = left_ff;
      right_in   = right_ff;
      busy_in    = busy_ff;
      kind_in    = kind_ff;
      elapsed_in = elapsed_ff;
      case (item.command)
         KIND_TICK: begin
            if (busy_ff) begin
               elapsed_in = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 16'd1;
               if (kind_ff == MANOEUVRE_SIX) begin
                  if (elapsed_in < cfg.fwd_phase_ms) begin
                     left_in  = drive_wheel(1'b0, cfg.speed);
                     right_in = drive_wheel(1'b0, cfg.speed);
                  end else if (elapsed_in < cfg.turn_end_ms) begin
                     left_in  = drive_wheel(1'b1, cfg.speed);
                     right_in = drive_wheel(1'b0, cfg.speed);
                  end else if (elapsed_in < cfg.final_end_ms) begin
                     left_in  = drive_wheel(1'b0, cfg.speed);
                     right_in = drive_wheel(1'b0, cfg.speed);
                  end else begin
                     left_in  = WHEEL_STOP;
                     right_in = WHEEL_STOP;
                     busy_in  = 1'b0;
                  end
               end else begin
                  if (elapsed_in < cfg.reverse_ms) begin
                     left_in  = drive_wheel(1'b1, cfg.speed);
                     right_in = drive_wheel(1'b1, cfg.speed);
                  end else begin
                     left_in  = WHEEL_STOP;
                     right_in = WHEEL_STOP;
                     busy_in  = 1'b0;
                  end
               end
            end
         end
         KIND_BYTE: begin
            case (item.rx_byte)
               BYTE_FWD: begin
                  left_in  = drive_wheel(1'b0, cfg.speed);
                  right_in = drive_wheel(1'b0, cfg.speed);
               end
               BYTE_REV: begin
                  left_in  = drive_wheel(1'b1, cfg.speed);
                  right_in = drive_wheel(1'b1, cfg.speed);
               end
               BYTE_RSPIN: begin
                  left_in  = drive_wheel(1'b0, spin);
                  right_in = drive_wheel(1'b1, spin);
               end
               BYTE_LSPIN: begin
                  left_in  = drive_wheel(1'b1, spin);
                  right_in = drive_wheel(1'b0, spin);
               end
               BYTE_NOP: ;
               BYTE_MAN_SIX, BYTE_MAN_SEV: begin
                  // ignored while a manoeuvre is running
                  if (!busy_ff) begin
                     elapsed_in = 16'd0;
                     busy_in    = 1'b1;
                     kind_in    = (item.rx_byte == BYTE_MAN_SEV) ? MANOEUVRE_SEVEN
                                                                 : MANOEUVRE_SIX;
                     left_in    = drive_wheel(kind_in, cfg.speed);
                     right_in   = drive_wheel(kind_in, cfg.speed);
                  end
               end
               default: begin
                  left_in  = WHEEL_STOP;
                  right_in = WHEEL_STOP;
                  busy_in  = 1'b0;
               end
            endcase
         end
         KIND_IR: begin
            if (item.ir_sample >= cfg.near_threshold) begin
               left_in  = WHEEL_STOP;
               right_in = WHEEL_STOP;
               busy_in  = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff    <= WHEEL_STOP;
         right_ff   <= WHEEL_STOP;
         busy_ff    <= 1'b0;
         kind_ff    <= MANOEUVRE_SIX;
         elapsed_ff <= 16'd0;
      end else if (update) begin
         left_ff    <= left_in;
         right_ff   <= right_in;
         busy_ff    <= busy_in;
         kind_ff    <= kind_in;
         elapsed_ff <= elapsed_in;
      end
   end

   assign result_next.left_forward   = left_in.forward;
   assign result_next.left_duty      = left_in.duty;
   assign result_next.right_forward  = right_in.forward;
   assign result_next.right_duty     = right_in.duty;
   assign result_next.manoeuvre_busy = busy_in;

endmodule

`default_nettype wire

// ----- src/robot_drive_command_sequencer_top.sv -----
// Robot drive command sequencer, top level.
// An item waits in the input register stage until the result register is free, then is
// applied to the drive state and its result is registered in the result register stage.
// Throughput: one item per cycle while responses are accepted without stalling.
// Reset (synchronous, active high): wheels forward at duty 0, idle, config at defaults.
`default_nettype none

module robot_drive_command_sequencer_top import rdcs_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   rdcs_req_if.sink                    req_ch,
   rdcs_rsp_if.source                  rsp_ch,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type    cfg;
   item_type   req_item;
   result_type result_next;

   // input register stage
   logic       s1_valid_ff, s1_valid_in;
   item_type   s1_item_ff;
   // result register stage
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_result_ff;

   logic req_xfer;
   logic advance;   // s1 item applied to the drive state this cycle

   assign req_item.command   = req_ch.command;
   assign req_item.rx_byte   = req_ch.rx_byte;
   assign req_item.ir_sample = req_ch.ir_sample;

   // s1 moves on whenever the result register is empty or being drained
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_xfer     = req_ch.valid && req_ch.ready;

   assign s1_valid_in  = req_xfer || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ch.ready);

   rdcs_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rdcs_drive_core u_core (
      .clock       (clock),
      .reset       (reset),
      .update      (advance),
      .item        (s1_item_ff),
      .cfg         (cfg),
      .result_next (result_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_item_ff <= req_item;
      end
      if (advance) begin
         rsp_result_ff <= result_next;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.left_forward   = rsp_result_ff.left_forward;
   assign rsp_ch.left_duty      = rsp_result_ff.left_duty;
   assign rsp_ch.right_forward  = rsp_result_ff.right_forward;
   assign rsp_ch.right_duty     = rsp_result_ff.right_duty;
   assign rsp_ch.manoeuvre_busy = rsp_result_ff.manoeuvre_busy;

   // ---- assertions ----

   // nothing is left in flight across reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!s1_valid_ff && !rsp_valid_ff))
      else $error("pipeline not empty after reset");

   // request side only stalls when both stages are full and the response is held
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_ch.ready))
      else $error("request stalled without a full pipeline");

   // a blocked s1 item keeps its payload
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_item_ff)))
      else $error("s1 item lost while blocked");

   // a wheel at zero duty always reads forward
   a_zero_fwd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_result_ff.left_duty == 8'd0 || rsp_result_ff.right_duty == 8'd0))
      |-> ((rsp_result_ff.left_duty != 8'd0 || rsp_result_ff.left_forward) &&
           (rsp_result_ff.right_duty != 8'd0 || rsp_result_ff.right_forward)))
      else $error("zero duty with reverse direction");

endmodule

`default_nettype wire
